FILE: rtl/ascon_pkg.sv
// ----------------------------------------------------------------------------
// Ascon AEAD encryption package
// Shared types, codes and the permutation round used by the encryption core.
// ----------------------------------------------------------------------------
`default_nettype none

package ascon_pkg;

  // The sponge is five 64-bit words; word 0 is the rate word.
  typedef logic [4:0][63:0] sponge_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_TAG0,
    ST_TAG1
  } state_t;

  // Protocol phase of the message under way.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INIT,
    PH_AD,
    PH_MSG
  } phase_t;

  // Work that follows the last round of a permutation.
  typedef enum logic [1:0] {
    POST_INIT,
    POST_ABSORB,
    POST_FINAL
  } post_t;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_AD    = 2'd1;
  localparam logic [1:0] MODE_MSG   = 2'd2;

  localparam logic [1:0] KIND_CT    = 2'd0;
  localparam logic [1:0] KIND_TAG0  = 2'd1;
  localparam logic [1:0] KIND_TAG1  = 2'd2;

  localparam logic       CFG_KEY_HIGH = 1'b0;
  localparam logic       CFG_KEY_LOW  = 1'b1;

  localparam logic [63:0] IV_WORD    = 64'h800C_0600_0000_0000;
  localparam logic [3:0]  FULL_BYTES = 4'd8;
  localparam logic [3:0]  LAST_A     = 4'd11;  // last round index of 12 rounds
  localparam logic [3:0]  LAST_B     = 4'd5;   // last round index of 6 rounds

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  // One round of the permutation; rnd is the round index within the call.
  function automatic sponge_t perm_round(input sponge_t s, input logic [3:0] rnd);
    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] t0, t1, t2, t3, t4;
    x0 = s[0];
    x1 = s[1];
    x2 = s[2];
    x3 = s[3];
    x4 = s[4];
    x2 = x2 ^ {56'd0, 4'hF - rnd, rnd};
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = ~x0 & x1;
    t1 = ~x1 & x2;
    t2 = ~x2 & x3;
    t3 = ~x3 & x4;
    t4 = ~x4 & x0;
    x0 = x0 ^ t1;
    x1 = x1 ^ t2;
    x2 = x2 ^ t3;
    x3 = x3 ^ t4;
    x4 = x4 ^ t0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;
    perm_round[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    perm_round[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    perm_round[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
    perm_round[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    perm_round[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ascon_aead_encrypt.sv
// ----------------------------------------------------------------------------
// Ascon AEAD encryption core
// Ascon-128 style encryption with a 64-bit rate, one block per input beat.
// ----------------------------------------------------------------------------
// Usage: write the key through the cfg channel (index 0 high half, index 1
// low half) while the core is idle. Send a start beat with the nonce, then
// optional associated-data beats, then plaintext beats; a beat with fewer
// than eight valid bytes ends its phase. Beats that do not fit the current
// phase are accepted and dropped without a result.
// Each plaintext beat yields one ciphertext beat (none for an empty final
// block); the final plaintext beat is followed by two tag beats.
// One permutation round runs per cycle on a single shared round unit; a
// start beat runs 12 rounds, a final block 12 rounds followed by the two
// tag beats, and an AD or full plaintext block 6 rounds; ignored beats
// run no rounds.
// A ciphertext beat appears on the output in the cycle after acceptance; the
// tags follow the last of the 12 finalization rounds.
// Results sit in an output register; when the receiver stalls, the core
// finishes its rounds and then waits with the next tag beat, and in_ready
// stays low until the output register can take a new beat.
// Reset clears the key, the sponge and the phase and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_aead_encrypt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [63:0] in_data_word,
  input  wire logic [3:0]  in_valid_bytes,
  input  wire logic [63:0] in_nonce_high,
  input  wire logic [63:0] in_nonce_low,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_word,
  output logic [3:0]       out_bytes,
  output logic [1:0]       out_kind,
  output logic             out_is_last
);

  ascon_pkg::state_t  state_r, state_nxt;
  ascon_pkg::phase_t  phase_r, phase_nxt;
  ascon_pkg::post_t   post_r, post_nxt;
  ascon_pkg::sponge_t sponge_r, sponge_nxt;
  logic               sep_r, sep_nxt;
  logic [3:0]         rnd_r, rnd_nxt;
  logic [3:0]         last_r, last_nxt;
  logic [63:0]        key_high_r, key_low_r;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_word_r, out_word_nxt;
  logic [3:0]         out_bytes_r, out_bytes_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               in_fire;
  logic [3:0]         vb;
  logic [63:0]        bmask;
  logic [63:0]        pad_blk;
  logic [63:0]        msg_word;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ascon_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;

  assign out_valid   = out_valid_r;
  assign out_word    = out_word_r;
  assign out_bytes   = out_bytes_r;
  assign out_kind    = out_kind_r;
  assign out_is_last = out_last_r;

  // Clamp the byte count and build the left-aligned mask and padded block.
  assign vb       = (in_valid_bytes > ascon_pkg::FULL_BYTES) ? ascon_pkg::FULL_BYTES
                                                             : in_valid_bytes;
  assign bmask    = vb[3] ? '1 : ~({64{1'b1}} >> {vb[2:0], 3'b000});
  assign pad_blk  = (in_data_word & bmask) |
                    (vb[3] ? 64'd0 : (64'h8000_0000_0000_0000 >> {vb[2:0], 3'b000}));
  assign msg_word = sponge_r[0] ^ pad_blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index[0])
        ascon_pkg::CFG_KEY_HIGH: if (cfg_index[1] == 1'b0) key_high_r <= cfg_data;
        ascon_pkg::CFG_KEY_LOW:  if (cfg_index[1] == 1'b0) key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ascon_pkg::ST_IDLE;
      phase_r     <= ascon_pkg::PH_IDLE;
      sep_r       <= 1'b0;
      sponge_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      sep_r       <= sep_nxt;
      sponge_r    <= sponge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    post_r      <= post_nxt;
    rnd_r       <= rnd_nxt;
    last_r      <= last_nxt;
    out_word_r  <= out_word_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    post_nxt      = post_r;
    sponge_nxt    = sponge_r;
    sep_nxt       = sep_r;
    rnd_nxt       = rnd_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_bytes_nxt = out_bytes_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ascon_pkg::ST_IDLE: begin
        if (in_fire) begin
          rnd_nxt = '0;
          priority if (in_mode == ascon_pkg::MODE_START &&
                       phase_r == ascon_pkg::PH_IDLE) begin
            sponge_nxt[0] = ascon_pkg::IV_WORD;
            sponge_nxt[1] = key_high_r;
            sponge_nxt[2] = key_low_r;
            sponge_nxt[3] = in_nonce_high;
            sponge_nxt[4] = in_nonce_low;
            sep_nxt       = 1'b0;
            phase_nxt     = ascon_pkg::PH_INIT;
            post_nxt      = ascon_pkg::POST_INIT;
            last_nxt      = ascon_pkg::LAST_A;
            state_nxt     = ascon_pkg::ST_ROUND;
          end else if (in_mode == ascon_pkg::MODE_AD &&
                       (phase_r == ascon_pkg::PH_INIT || phase_r == ascon_pkg::PH_AD)) begin
            sponge_nxt[0] = sponge_r[0] ^ pad_blk;
            phase_nxt     = vb[3] ? ascon_pkg::PH_AD : ascon_pkg::PH_MSG;
            post_nxt      = ascon_pkg::POST_ABSORB;
            last_nxt      = ascon_pkg::LAST_B;
            state_nxt     = ascon_pkg::ST_ROUND;
          end else if (in_mode == ascon_pkg::MODE_MSG &&
                       (phase_r == ascon_pkg::PH_INIT || phase_r == ascon_pkg::PH_MSG)) begin
            // Domain separation bit goes in together with the first plaintext block.
            sponge_nxt[4] = sponge_r[4] ^ {63'd0, !sep_r};
            sponge_nxt[0] = msg_word;
            sep_nxt       = 1'b1;
            state_nxt     = ascon_pkg::ST_ROUND;
            if (vb != 4'd0) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = msg_word & bmask;
              out_bytes_nxt = vb;
              out_kind_nxt  = ascon_pkg::KIND_CT;
              out_last_nxt  = 1'b0;
            end
            if (vb[3]) begin
              phase_nxt = ascon_pkg::PH_MSG;
              post_nxt  = ascon_pkg::POST_ABSORB;
              last_nxt  = ascon_pkg::LAST_B;
            end else begin
              sponge_nxt[1] = sponge_r[1] ^ key_high_r;
              sponge_nxt[2] = sponge_r[2] ^ key_low_r;
              phase_nxt     = ascon_pkg::PH_IDLE;
              post_nxt      = ascon_pkg::POST_FINAL;
              last_nxt      = ascon_pkg::LAST_A;
            end
          end else begin
            // Out-of-order beat: dropped.
            state_nxt = ascon_pkg::ST_IDLE;
          end
        end
      end

      ascon_pkg::ST_ROUND: begin
        sponge_nxt = ascon_pkg::perm_round(sponge_r, rnd_r);
        rnd_nxt    = rnd_r + 4'd1;
        if (rnd_r == last_r) begin
          unique case (post_r)
            ascon_pkg::POST_INIT: begin
              sponge_nxt[3] = sponge_nxt[3] ^ key_high_r;
              sponge_nxt[4] = sponge_nxt[4] ^ key_low_r;
              state_nxt     = ascon_pkg::ST_IDLE;
            end
            ascon_pkg::POST_FINAL: begin
              sponge_nxt[3] = sponge_nxt[3] ^ key_high_r;
              sponge_nxt[4] = sponge_nxt[4] ^ key_low_r;
              sep_nxt       = 1'b0;
              state_nxt     = ascon_pkg::ST_TAG0;
            end
            default: state_nxt = ascon_pkg::ST_IDLE;
          endcase
        end
      end

      ascon_pkg::ST_TAG0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = sponge_r[3];
          out_bytes_nxt = ascon_pkg::FULL_BYTES;
          out_kind_nxt  = ascon_pkg::KIND_TAG0;
          out_last_nxt  = 1'b0;
          state_nxt     = ascon_pkg::ST_TAG1;
        end
      end

      ascon_pkg::ST_TAG1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = sponge_r[4];
          out_bytes_nxt = ascon_pkg::FULL_BYTES;
          out_kind_nxt  = ascon_pkg::KIND_TAG1;
          out_last_nxt  = 1'b1;
          state_nxt     = ascon_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ascon_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire
